@@ hw/rtl/fqs_pkg.sv @@
package fqs_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic [1:0] KIND_ENQ    = 2'd0;
    localparam logic [1:0] KIND_DEQ    = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic [4:0]         entry_count;
        logic               is_empty;
    } out_word_t;

    // Search unit start request
    typedef struct packed {
        logic   start;
        ptr_t   ptr;
        count_t count;
    } scan_req_t;

    // Search unit report
    typedef struct packed {
        logic done;
        logic hit;
        ptr_t addr;
    } scan_rsp_t;

    // Advance a pointer around the ring
    function automatic ptr_t wrap_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/fqs_store.sv @@
module fqs_store (
    input  logic                 clk,
    input  logic                 wr_en,
    input  fqs_pkg::ptr_t        wr_addr,
    input  logic [31:0]          wr_data,
    input  fqs_pkg::ptr_t        rd_addr,
    output logic [31:0]          rd_data
);

    logic [31:0] mem [fqs_pkg::DEPTH];
    logic [31:0] rd_data_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one word, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/fqs_scan.sv @@
module fqs_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  fqs_pkg::scan_req_t  req,
    input  logic [31:0]         rd_data,
    input  logic [31:0]         key,
    output fqs_pkg::scan_rsp_t  rsp
);

    logic            busy_reg;
    logic            data_ok_reg;
    fqs_pkg::ptr_t   ptr_reg;
    fqs_pkg::count_t left_reg;
    logic            hit;
    logic            done;

    // Shared compare against the word read last cycle
    assign hit  = data_ok_reg && (rd_data == key);
    assign done = data_ok_reg && (hit || left_reg == fqs_pkg::COUNT_W'(1));

    // Walk the occupied entries, one read and one compare per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            data_ok_reg <= 1'b0;
            ptr_reg     <= '0;
            left_reg    <= '0;
        end
        else if (req.start)
        begin
            busy_reg    <= 1'b1;
            data_ok_reg <= 1'b0;
            ptr_reg     <= req.ptr;
            left_reg    <= req.count;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg    <= 1'b0;
                data_ok_reg <= 1'b0;
            end
            else
            begin
                data_ok_reg <= 1'b1;
                ptr_reg     <= fqs_pkg::wrap_next(ptr_reg);
                if (data_ok_reg)
                begin
                    left_reg <= left_reg - fqs_pkg::COUNT_W'(1);
                end
            end
        end
    end

    assign rsp.done = done;
    assign rsp.hit  = hit;
    assign rsp.addr = ptr_reg;

endmodule

@@ hw/rtl/fifo_queue_with_search.sv @@
// Bounded FIFO of signed 32-bit words with a search operation.
// Input channel in_valid/in_stall/in_data carries one operation word (kind,
// value): enqueue, dequeue, search or clear. Each accepted word yields exactly
// one result word on out_valid/out_stall/out_data: status, found flag, front
// and rear words (-1 when empty), count and empty flag after the operation.
// One operation is in flight at a time; in_stall is high while it runs.
// Enqueue, clear and any operation on an empty queue pass through the states
// EXEC and RESP; a dequeue adds FRONT to read the new head, and a search adds
// SCAN, which compares one entry per read until a hit or the count is spent,
// since the search streams the ring through the single read port of the entry
// memory into one shared 32-bit comparator. in_stall drops in the same cycle
// that out_valid rises, so a new word is taken only once the last one has
// written its result.
// The result sits in an output register; the next operation may be accepted
// while it waits. If out_stall holds the result, the following operation
// finishes its work and then waits before writing its result.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending
// result; the entry memory is not cleared, as only occupied entries are read.
module fifo_queue_with_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fqs_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fqs_pkg::out_word_t out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FRONT,
        S_SCAN,
        S_RESP
    } state_t;

    state_t             state_reg;
    fqs_pkg::in_word_t  op_reg;
    fqs_pkg::ptr_t      head_reg;
    fqs_pkg::ptr_t      tail_reg;
    fqs_pkg::count_t    count_reg;
    logic [31:0]        front_reg;
    logic [31:0]        rear_reg;
    logic [1:0]         status_reg;
    logic               found_reg;
    logic               out_valid_reg;
    fqs_pkg::out_word_t out_reg;

    logic               wr_en;
    fqs_pkg::ptr_t      rd_addr;
    logic [31:0]        rd_data;
    fqs_pkg::scan_req_t scan_req;
    fqs_pkg::scan_rsp_t scan_rsp;
    logic               is_full;
    logic               is_none;
    logic               out_free;

    assign is_full  = (count_reg == fqs_pkg::COUNT_W'(fqs_pkg::DEPTH));
    assign is_none  = (count_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;

    // Store on an enqueue with room
    assign wr_en = (state_reg == S_EXEC) && (op_reg.kind == fqs_pkg::KIND_ENQ) && !is_full;

    // Read the next head for a dequeue, else follow the search walk
    assign rd_addr = (state_reg == S_EXEC) ? fqs_pkg::wrap_next(head_reg) : scan_rsp.addr;

    // Start a search walk at the head
    assign scan_req.start = (state_reg == S_EXEC) && (op_reg.kind == fqs_pkg::KIND_SEARCH)
                            && !is_none;
    assign scan_req.ptr   = head_reg;
    assign scan_req.count = count_reg;

    fqs_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (op_reg.value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fqs_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .rd_data (rd_data),
        .key     (op_reg.value),
        .rsp     (scan_rsp)
    );

    // Sequence one operation and hold the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= '0;
            front_reg     <= '0;
            rear_reg      <= '0;
            status_reg    <= fqs_pkg::ST_DONE;
            found_reg     <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // Raise the result flag on a new word, drop it once taken
            if ((state_reg == S_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= in_data;
                        found_reg <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (op_reg.kind)
                        fqs_pkg::KIND_ENQ:
                        begin
                            state_reg <= S_RESP;
                            if (is_full)
                            begin
                                status_reg <= fqs_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_reg <= fqs_pkg::ST_DONE;
                                tail_reg   <= fqs_pkg::wrap_next(tail_reg);
                                count_reg  <= count_reg + fqs_pkg::COUNT_W'(1);
                                rear_reg   <= op_reg.value;
                                if (is_none)
                                begin
                                    front_reg <= op_reg.value;
                                end
                            end
                        end
                        fqs_pkg::KIND_DEQ:
                        begin
                            if (is_none)
                            begin
                                status_reg <= fqs_pkg::ST_EMPTY;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                status_reg <= fqs_pkg::ST_DONE;
                                head_reg   <= fqs_pkg::wrap_next(head_reg);
                                count_reg  <= count_reg - fqs_pkg::COUNT_W'(1);
                                state_reg  <= S_FRONT;
                            end
                        end
                        fqs_pkg::KIND_SEARCH:
                        begin
                            if (is_none)
                            begin
                                status_reg <= fqs_pkg::ST_EMPTY;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                status_reg <= fqs_pkg::ST_DONE;
                                state_reg  <= S_SCAN;
                            end
                        end
                        fqs_pkg::KIND_CLEAR:
                        begin
                            state_reg <= S_RESP;
                            if (is_none)
                            begin
                                status_reg <= fqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                status_reg <= fqs_pkg::ST_DONE;
                                head_reg   <= '0;
                                tail_reg   <= '0;
                                count_reg  <= '0;
                            end
                        end
                        default:
                        begin
                            status_reg <= fqs_pkg::ST_DONE;
                            state_reg  <= S_RESP;
                        end
                    endcase
                end
                S_FRONT:
                begin
                    front_reg <= rd_data;
                    state_reg <= S_RESP;
                end
                S_SCAN:
                begin
                    if (scan_rsp.done)
                    begin
                        found_reg <= scan_rsp.hit;
                        state_reg <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_reg.status      <= status_reg;
                        out_reg.found       <= found_reg;
                        out_reg.front_value <= is_none ? '1 : front_reg;
                        out_reg.rear_value  <= is_none ? '1 : rear_reg;
                        out_reg.entry_count <= 5'(count_reg);
                        out_reg.is_empty    <= is_none;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ tb/sv/tb.sv @@
module tb;

    // Track outstanding queue results and check each returned word
    class result_board;
        logic signed [31:0]  held[$];
        fqs_pkg::out_word_t  expected_words[$];
        int                  mismatches;
        int                  results_checked;
        int                  kinds_seen[4];
        int                  status_seen[3];
        int                  search_hits;

        function new();
            mismatches      = 0;
            results_checked = 0;
            search_hits     = 0;
            foreach (kinds_seen[k])
            begin
                kinds_seen[k] = 0;
            end
            foreach (status_seen[s])
            begin
                status_seen[s] = 0;
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH at result %0d: %s", results_checked, msg);
        endtask

        // Apply one operation to the shadow queue and build the result word
        function fqs_pkg::out_word_t predict_op(fqs_pkg::in_word_t w);
            fqs_pkg::out_word_t r;
            r        = '0;
            r.status = fqs_pkg::ST_DONE;
            case (w.kind)
                fqs_pkg::KIND_ENQ:
                begin
                    if (held.size() >= fqs_pkg::DEPTH)
                    begin
                        r.status = fqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        held.push_back(w.value);
                    end
                end
                fqs_pkg::KIND_DEQ:
                begin
                    if (held.size() == 0)
                    begin
                        r.status = fqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        void'(held.pop_front());
                    end
                end
                fqs_pkg::KIND_SEARCH:
                begin
                    if (held.size() == 0)
                    begin
                        r.status = fqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        foreach (held[i])
                        begin
                            if (held[i] == w.value)
                            begin
                                r.found = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    if (held.size() == 0)
                    begin
                        r.status = fqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        held.delete();
                    end
                end
            endcase
            // Report -1 at both ends of an empty queue
            if (held.size() == 0)
            begin
                r.front_value = -32'sd1;
                r.rear_value  = -32'sd1;
                r.is_empty    = 1'b1;
            end
            else
            begin
                r.front_value = held[0];
                r.rear_value  = held[held.size() - 1];
                r.is_empty    = 1'b0;
            end
            r.entry_count = 5'(held.size());
            return r;
        endfunction

        // Note an accepted operation word
        function void note_op(fqs_pkg::in_word_t w);
            fqs_pkg::out_word_t r;
            r = predict_op(w);
            expected_words.push_back(r);
            kinds_seen[w.kind]++;
            if (r.status <= fqs_pkg::ST_FULL)
            begin
                status_seen[r.status]++;
            end
            if (r.found)
            begin
                search_hits++;
            end
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %0h, want %0h", name, got, want));
            end
        endtask

        // Compare a returned word against the oldest expectation
        task check_result(fqs_pkg::out_word_t got);
            fqs_pkg::out_word_t want;
            if (expected_words.size() == 0)
            begin
                report("result word with nothing outstanding");
                return;
            end
            want = expected_words.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("found", 32'(got.found), 32'(want.found));
            compare_field("front_value", got.front_value, want.front_value);
            compare_field("rear_value", got.rear_value, want.rear_value);
            compare_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            compare_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
            results_checked++;
        endtask

        function int outstanding();
            return expected_words.size();
        endfunction

        // Pick a stored word so searches hit often
        function logic [31:0] pick_held();
            if (held.size() == 0)
            begin
                return $urandom();
            end
            return held[$urandom_range(0, held.size() - 1)];
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    fqs_pkg::in_word_t  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    fqs_pkg::out_word_t out_data;

    result_board board;
    bit          no_gaps    = 1'b0;
    int          sent_count = 0;

    fifo_queue_with_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Watch both channels at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                board.note_op(in_data);
            end
            if (out_valid && !out_stall)
            begin
                board.check_result(out_data);
            end
        end
    end

    // Stall the result channel for a random number of cycles per word
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 12);
            repeat (hold)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    // Present one operation word after a random gap and hold it until taken
    task send_op(logic [1:0] kind, logic [31:0] value);
        int                gap;
        fqs_pkg::in_word_t w;
        gap     = no_gaps ? 0 : $urandom_range(0, 12);
        w.kind  = kind;
        w.value = value;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sent_count++;
    endtask

    // Hold off the sender until every result is back
    task wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    // Draw a word: extremes, a small pool that repeats, or any value
    function logic [31:0] draw_value();
        case ($urandom_range(0, 5))
            0:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            2, 3:    return 32'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // Run a stretch of random operations with the given mix
    task run_phase(int count, int enq_w, int deq_w, int srch_w, int clr_w);
        int          pick;
        logic [31:0] v;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, enq_w + deq_w + srch_w + clr_w - 1);
            if (pick < enq_w)
            begin
                send_op(fqs_pkg::KIND_ENQ, draw_value());
            end
            else if (pick < enq_w + deq_w)
            begin
                send_op(fqs_pkg::KIND_DEQ, $urandom());
            end
            else if (pick < enq_w + deq_w + srch_w)
            begin
                v = ($urandom_range(0, 1) != 0) ? board.pick_held() : draw_value();
                send_op(fqs_pkg::KIND_SEARCH, v);
            end
            else
            begin
                send_op(fqs_pkg::KIND_CLEAR, $urandom());
            end
        end
    endtask

    initial
    begin
        int profile;
        int len;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operations on an empty queue
        send_op(fqs_pkg::KIND_DEQ, 32'h0);
        send_op(fqs_pkg::KIND_CLEAR, 32'h0);
        send_op(fqs_pkg::KIND_SEARCH, 32'h0);
        // Extremes, search hit and miss, dequeue, clear with words held
        send_op(fqs_pkg::KIND_ENQ, 32'h7FFF_FFFF);
        send_op(fqs_pkg::KIND_ENQ, 32'h8000_0000);
        send_op(fqs_pkg::KIND_SEARCH, 32'h8000_0000);
        send_op(fqs_pkg::KIND_SEARCH, 32'h0);
        send_op(fqs_pkg::KIND_DEQ, 32'hFFFF_FFFF);
        send_op(fqs_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
        // Fill to the top, then overflow and search the newest word
        for (int k = 0; k < fqs_pkg::DEPTH; k++)
        begin
            if (k == 0)
            begin
                send_op(fqs_pkg::KIND_ENQ, 32'hFFFF_FFFF);
            end
            else if (k == 1)
            begin
                send_op(fqs_pkg::KIND_ENQ, 32'h0);
            end
            else
            begin
                send_op(fqs_pkg::KIND_ENQ, 32'hA5A5_0000 | 32'(k));
            end
        end
        send_op(fqs_pkg::KIND_ENQ, 32'h1234_5678);
        send_op(fqs_pkg::KIND_SEARCH, 32'hA5A5_0000 | 32'(fqs_pkg::DEPTH - 1));
        wait_for_results();

        // Random phases: fill, drain, balanced, search heavy
        while (sent_count < 800)
        begin
            profile = $urandom_range(0, 3);
            len     = $urandom_range(30, 70);
            no_gaps = ($urandom_range(0, 3) == 0);
            case (profile)
                0:       run_phase(len, 65, 15, 18, 2);
                1:       run_phase(len, 20, 60, 17, 3);
                2:       run_phase(len, 40, 35, 22, 3);
                default: run_phase(len, 30, 20, 48, 2);
            endcase
            if ($urandom_range(0, 2) == 0)
            begin
                wait_for_results();
            end
        end
        no_gaps = 1'b0;

        // Drain and allow for any stray word
        wait_for_results();
        repeat (40) @(posedge clk);

        $display("covered %0d operations: enqueue %0d, dequeue %0d, search %0d, clear %0d",
                 sent_count, board.kinds_seen[fqs_pkg::KIND_ENQ],
                 board.kinds_seen[fqs_pkg::KIND_DEQ],
                 board.kinds_seen[fqs_pkg::KIND_SEARCH],
                 board.kinds_seen[fqs_pkg::KIND_CLEAR]);
        $display("%0d results checked: done %0d, empty %0d, full %0d, search hits %0d",
                 board.results_checked, board.status_seen[fqs_pkg::ST_DONE],
                 board.status_seen[fqs_pkg::ST_EMPTY],
                 board.status_seen[fqs_pkg::ST_FULL], board.search_hits);
        if (board.mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
